[src/flc_pkg.sv]
package flc_pkg;

  // Kernel capacity and derived widths
  localparam int MAX_TAPS = 32;
  localparam int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Fixed field widths
  localparam int SMP_W    = 16;
  localparam int PROD_W   = 2 * SMP_W;
  localparam int ACC_W    = 38;
  localparam int KT_W     = 6;
  localparam int TIDX_W   = 5;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Register map (word index)
  localparam logic REG_KERNEL_TAPS = 1'b0;
  localparam logic [KT_W-1:0] KERNEL_TAPS_RST = KT_W'(1);

  // Item operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [TIDX_W-1:0]       tap_index;
    logic signed [SMP_W-1:0] value;
    logic                    last_sample;
  } flc_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] conv_value;
    logic                    last_output;
  } flc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } flc_state_t;

  typedef struct packed {
    logic             tap_we;
    logic [IDX_W-1:0] tap_idx;
    logic             shift_en;
    logic             clear;
  } flc_data_ctrl_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } flc_mac_ctrl_t;

  // Zero acts as one, anything above capacity acts as full capacity
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [KT_W-1:0] kt);
    logic [CNT_W-1:0] n;
    if (kt == '0) begin
      n = CNT_W'(1);
    end else if (int'(kt) > MAX_TAPS) begin
      n = CNT_W'(MAX_TAPS);
    end else begin
      n = CNT_W'(kt);
    end
    return n;
  endfunction

endpackage

[src/full_linear_convolution_core.sv]
// Full linear convolution core: a direct-form FIR over a stored kernel of up
// to MAX_TAPS Q1.15 taps. A load transaction (operation 0) writes one tap and
// gives no result; loads to a tap index beyond capacity are dropped. A sample
// transaction (operation 1) shifts the sample into the delay line and gives
// one output, the exact 38-bit sum of tap*sample products. A sample marked
// last_sample is followed by n-1 flush outputs with zero input, the final
// output flagged last_output, after which the delay line is cleared. The
// core owns one 16x16 multiplier and one 38-bit accumulator that walk the
// taps one per cycle, n being kernel_taps clamped to 1..MAX_TAPS. A sample
// passes through the accepting cycle, the issue of each of the n taps, a
// pipeline drain and a hand-over to the output register, which raises
// out_valid; each flush output repeats the issue, drain and hand-over.
// in_ready is low for the whole of a sample and its flush. The output
// register lets a finished result wait for the sink while the core returns
// to idle and takes the next transaction; a hand-over stalls only if the
// previous output is still waiting. kernel_taps sits at APB byte address 0
// and should be written only while the core is idle; it resets to 1.
module full_linear_convolution_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  flc_pkg::flc_in_t             in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output flc_pkg::flc_out_t            out_data,
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flc_pkg::APB_AW-1:0]   paddr,
  input  logic [flc_pkg::APB_DW-1:0]   pwdata,
  output logic [flc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import flc_pkg::*;

  flc_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;       // tap being issued
  logic [CNT_W-1:0]        n_r, n_nxt;           // taps in use for this signal
  logic [CNT_W-1:0]        flush_r, flush_nxt;   // flush outputs still owed
  logic                    last_r, last_nxt;     // current sample was the last
  logic                    out_valid_r;
  flc_out_t                out_data_r;
  logic                    out_free;
  logic                    out_load;

  logic [KT_W-1:0]         kernel_taps;
  flc_data_ctrl_t          dctl;
  flc_mac_ctrl_t           mctl;
  logic signed [SMP_W-1:0] wr_value;
  logic signed [SMP_W-1:0] tap_q;
  logic signed [SMP_W-1:0] smp_q;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_busy;

  flc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .kernel_taps (kernel_taps)
  );

  flc_data u_data (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (dctl),
    .wr_value (wr_value),
    .rd_idx   (cnt_r[IDX_W-1:0]),
    .tap_q    (tap_q),
    .smp_q    (smp_q)
  );

  flc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mctl),
    .tap   (tap_q),
    .smp   (smp_q),
    .acc   (acc),
    .busy  (mac_busy)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= CNT_W'(1);
      flush_r <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      flush_r <= flush_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    flush_nxt    = flush_r;
    last_nxt     = last_r;
    dctl         = '0;
    mctl         = '0;
    wr_value     = in_data.value;
    out_load     = 1'b0;
    dctl.tap_idx = IDX_W'(in_data.tap_index);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_LOAD) begin
            // out-of-range tap positions are dropped
            dctl.tap_we = (int'(in_data.tap_index) < MAX_TAPS);
          end else begin
            dctl.shift_en = 1'b1;
            mctl.clear    = 1'b1;
            n_nxt         = taps_in_use(kernel_taps);
            last_nxt      = in_data.last_sample;
            flush_nxt     = in_data.last_sample ? (n_nxt - CNT_W'(1)) : '0;
            cnt_nxt       = '0;
            state_nxt     = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        mctl.issue = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last product lands in the accumulator
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (flush_r != '0) begin
            // next flush step: shift in a zero sample
            wr_value      = '0;
            dctl.shift_en = 1'b1;
            mctl.clear    = 1'b1;
            flush_nxt     = flush_r - CNT_W'(1);
            cnt_nxt       = '0;
            state_nxt     = ST_MAC;
          end else begin
            dctl.clear = last_r;
            last_nxt   = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.conv_value  <= acc;
      out_data_r.last_output <= last_r && (flush_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new transaction never finds a product still in flight
  a_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !mac_busy)
    else $error("input accepted while MAC pipeline busy");

  // tap walk stays within the taps in use
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    mctl.issue |-> (cnt_r < n_r))
    else $error("tap index beyond taps in use");

  // flush outputs are owed only after a last sample
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r != '0) |-> last_r)
    else $error("flush pending without last sample");

  // results appear only from the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish step");

endmodule

[src/flc_cfg.sv]
module flc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flc_pkg::APB_AW-1:0]   paddr,
  input  logic [flc_pkg::APB_DW-1:0]   pwdata,
  output logic [flc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output logic [flc_pkg::KT_W-1:0]     kernel_taps
);
  import flc_pkg::*;

  logic [KT_W-1:0] kernel_taps_r;
  logic            hit_kt;

  // word index sits above the two byte-lane bits
  assign hit_kt = (paddr[APB_AW-1:2] == REG_KERNEL_TAPS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_taps_r <= KERNEL_TAPS_RST;
    end else if (psel && penable && pwrite && hit_kt) begin
      kernel_taps_r <= pwdata[KT_W-1:0];
    end
  end

  assign prdata      = hit_kt ? APB_DW'(kernel_taps_r) : '0;
  assign kernel_taps = kernel_taps_r;

endmodule

[src/flc_data.sv]
module flc_data (
  input  logic                               clk,
  input  logic                               rst_n,
  input  flc_pkg::flc_data_ctrl_t            ctrl,
  input  logic signed [flc_pkg::SMP_W-1:0]   wr_value,
  input  logic [flc_pkg::IDX_W-1:0]          rd_idx,
  output logic signed [flc_pkg::SMP_W-1:0]   tap_q,
  output logic signed [flc_pkg::SMP_W-1:0]   smp_q
);
  import flc_pkg::*;

  logic signed [SMP_W-1:0] tap_r  [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_r [MAX_TAPS];

  // coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        tap_r[i] <= '0;
      end
    end else if (ctrl.tap_we) begin
      tap_r[ctrl.tap_idx] <= wr_value;
    end
  end

  // delay line, newest sample at position 0
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (ctrl.shift_en) begin
      hist_r[0] <= wr_value;
      for (int i = 1; i < MAX_TAPS; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign tap_q = tap_r[rd_idx];
  assign smp_q = hist_r[rd_idx];

endmodule

[src/flc_mac.sv]
module flc_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  flc_pkg::flc_mac_ctrl_t             ctrl,
  input  logic signed [flc_pkg::SMP_W-1:0]   tap,
  input  logic signed [flc_pkg::SMP_W-1:0]   smp,
  output logic signed [flc_pkg::ACC_W-1:0]   acc,
  output logic                               busy
);
  import flc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r <= tap * smp;
    end
  end

  // accumulate stage; wraps modulo 2^ACC_W
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule
